[rtl/qtg_pkg.sv]
// Shared types and fixed widths of the quad tangent generator.
package qtg_pkg;

	localparam int FIELD_W = 16;
	localparam int TAN_W   = 16;
	localparam int A_W     = 30;
	localparam int SUM_W   = 62;
	localparam int ROOT_W  = 31;
	localparam int Q_W     = 15;
	localparam int DV_W    = A_W + Q_W + 1;
	localparam int CNT_W   = 5;
	localparam int ONE_Q14 = 16384;

	typedef struct packed {
		logic start;
		logic step;
		logic fin;
	} step_ctl_t;

endpackage

[rtl/qtg_dot2.sv]
// Bit-serial signed a*b - c*d lane, one multiplier bit per cycle.
module qtg_dot2 #(
	parameter int MW = 17
) (
	input  logic                    clk,
	input  qtg_pkg::step_ctl_t      ctl,
	input  logic signed [MW-1:0]    a,
	input  logic signed [MW-1:0]    b,
	input  logic signed [MW-1:0]    c,
	input  logic signed [MW-1:0]    d,
	output logic signed [2*MW:0]    prod
);

	localparam int PW = 2 * MW + 1;

	logic signed [PW-1:0] a_sh_q;
	logic signed [PW-1:0] c_sh_q;
	logic signed [PW-1:0] acc_q;
	logic signed [PW-1:0] ta;
	logic signed [PW-1:0] tc;
	logic [MW-1:0]        b_q;
	logic [MW-1:0]        d_q;

	always_comb begin
		ta = b_q[0] ? a_sh_q : '0;
		tc = d_q[0] ? c_sh_q : '0;
	end

	// sign bit of the multiplier carries negative weight
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_sh_q <= PW'(a);
			c_sh_q <= PW'(c);
			b_q    <= $unsigned(b);
			d_q    <= $unsigned(d);
			acc_q  <= '0;
		end else if (ctl.step) begin
			if (ctl.fin) begin
				acc_q <= acc_q - ta + tc;
			end else begin
				acc_q <= acc_q + ta - tc;
			end
			a_sh_q <= a_sh_q <<< 1;
			c_sh_q <= c_sh_q <<< 1;
			b_q    <= b_q >> 1;
			d_q    <= d_q >> 1;
		end
	end

	assign prod = acc_q;

endmodule

[rtl/qtg_sqmul.sv]
// Bit-serial unsigned squarer lane.
module qtg_sqmul (
	input  logic                          clk,
	input  qtg_pkg::step_ctl_t            ctl,
	input  logic [qtg_pkg::A_W-1:0]       a,
	output logic [2*qtg_pkg::A_W-1:0]     sq
);

	localparam int SQW = 2 * qtg_pkg::A_W;

	logic [SQW-1:0]          a_sh_q;
	logic [SQW-1:0]          acc_q;
	logic [qtg_pkg::A_W-1:0] m_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_sh_q <= SQW'(a);
			m_q    <= a;
			acc_q  <= '0;
		end else if (ctl.step) begin
			acc_q  <= acc_q + (m_q[0] ? a_sh_q : '0);
			a_sh_q <= a_sh_q << 1;
			m_q    <= m_q >> 1;
		end
	end

	assign sq = acc_q;

endmodule

[rtl/qtg_isqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
module qtg_isqrt (
	input  logic                          clk,
	input  qtg_pkg::step_ctl_t            ctl,
	input  logic [qtg_pkg::SUM_W-1:0]     x,
	output logic [qtg_pkg::ROOT_W-1:0]    root
);

	localparam int SW = qtg_pkg::SUM_W;

	logic [SW-1:0] x_q;
	logic [SW-1:0] res_q;
	logic [SW-1:0] one_q;
	logic [SW-1:0] trial;

	assign trial = res_q + one_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= x;
			res_q <= '0;
			one_q <= SW'(1) << (SW - 2);
		end else if (ctl.step) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
	end

	assign root = res_q[qtg_pkg::ROOT_W-1:0];

endmodule

[rtl/qtg_div.sv]
// Restoring divider lane: round((a * 2^15) / (2 * len)), one quotient bit per cycle.
module qtg_div (
	input  logic                          clk,
	input  qtg_pkg::step_ctl_t            ctl,
	input  logic [qtg_pkg::A_W-1:0]       a,
	input  logic [qtg_pkg::ROOT_W-1:0]    len,
	output logic [qtg_pkg::Q_W-1:0]       q
);

	localparam int DW = qtg_pkg::DV_W;
	localparam int QW = qtg_pkg::Q_W;

	logic [DW-1:0]                rem_q;
	logic [DW-1:0]                dsh_q;
	logic [QW-1:0]                q_q;
	logic [qtg_pkg::ROOT_W-1:0]   len_e;

	assign len_e = (len == '0) ? qtg_pkg::ROOT_W'(1) : len;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= DW'({a, QW'(0)}) + DW'(len_e);
			dsh_q <= DW'({len_e, 1'b0}) << (QW - 1);
			q_q   <= '0;
		end else if (ctl.step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[QW-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[QW-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign q = q_q;

endmodule

[rtl/quad_tangent_generator.sv]
// Top level: quad vertex capture, serial tangent datapath and result word output.
//
// channel  dir  handshake             word
// vtx      in   vtx_valid, vtx_stall  pos_x pos_y pos_z tex_u tex_v (Q4.12)
// tan      out  tan_valid, tan_stall  tan_x tan_y tan_z (Q1.14) corner last_of_quad degenerate
//
// Vertices 0..2 of a quad are never stalled. The fourth starts the quad work: the
// bit-serial multiplies, the normalizing shifts, the 31-step root and the divides.
// The four words then leave one per cycle while tan_stall is low. Reset clears quad
// position, sequencer and tan_valid. Vertices 0..2 of the next quad are taken during
// the work; its fourth vertex stalls until the last word of the current quad is taken.
module quad_tangent_generator #(
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  vtx_valid,
	output logic                                  vtx_stall,
	input  logic signed [qtg_pkg::FIELD_W-1:0]    pos_x,
	input  logic signed [qtg_pkg::FIELD_W-1:0]    pos_y,
	input  logic signed [qtg_pkg::FIELD_W-1:0]    pos_z,
	input  logic signed [qtg_pkg::FIELD_W-1:0]    tex_u,
	input  logic signed [qtg_pkg::FIELD_W-1:0]    tex_v,
	output logic                                  tan_valid,
	input  logic                                  tan_stall,
	output logic signed [qtg_pkg::TAN_W-1:0]      tan_x,
	output logic signed [qtg_pkg::TAN_W-1:0]      tan_y,
	output logic signed [qtg_pkg::TAN_W-1:0]      tan_z,
	output logic [1:0]                            corner,
	output logic                                  last_of_quad,
	output logic                                  degenerate
);

	localparam int CW = (COORD_BITS > 16) ? 17 : COORD_BITS;
	localparam int MW = CW + 1;
	localparam int RW = 2 * MW + 1;
	localparam int MG = (RW > qtg_pkg::A_W) ? RW : qtg_pkg::A_W + 1;
	localparam int NW = qtg_pkg::CNT_W;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_DOT   = 10'b0000000010,
		ST_MAG   = 10'b0000000100,
		ST_SHIFT = 10'b0000001000,
		ST_SQ    = 10'b0000010000,
		ST_SUM   = 10'b0000100000,
		ST_SQRT  = 10'b0001000000,
		ST_DIV   = 10'b0010000000,
		ST_FIN   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	function automatic logic signed [CW-1:0] ext_coord(input logic signed [15:0] x);
		if (COORD_BITS > 16) begin
			return CW'($unsigned(x));
		end else begin
			return CW'(x);
		end
	endfunction

	function automatic logic signed [qtg_pkg::TAN_W-1:0] mk_comp(
		input logic [qtg_pkg::Q_W-1:0] q,
		input logic                    neg
	);
		logic [qtg_pkg::Q_W-1:0]          qs;
		logic signed [qtg_pkg::TAN_W-1:0] v;
		qs = (q > qtg_pkg::Q_W'(qtg_pkg::ONE_Q14)) ? qtg_pkg::Q_W'(qtg_pkg::ONE_Q14) : q;
		v  = qtg_pkg::TAN_W'(qs);
		return neg ? -v : v;
	endfunction

	state_t            state_q;
	logic [NW-1:0]     cnt_q;
	logic [1:0]        idx_q;
	logic              tan_valid_q;
	logic [1:0]        corner_q;

	logic signed [CW-1:0] hp_q [3][3];
	logic signed [CW-1:0] ht_q [3][2];
	logic signed [CW-1:0] vin_p [3];
	logic signed [CW-1:0] vin_t [2];

	logic signed [MW-1:0] dp1 [3];
	logic signed [MW-1:0] dp2 [3];
	logic signed [MW-1:0] du1u, du1v, du2u, du2v;

	logic signed [RW-1:0] t_p [3];
	logic signed [RW-1:0] det_p;

	logic [MG-1:0]                  mag_q [3];
	logic [2:0]                     neg_q;
	logic                           degen_q;
	logic                           degen_now;
	logic                           need_sh;
	logic [2*qtg_pkg::A_W-1:0]      sq [3];
	logic [qtg_pkg::SUM_W-1:0]      sum_q;
	logic [qtg_pkg::SUM_W-1:0]      rt_x;
	logic [qtg_pkg::ROOT_W-1:0]     len;
	logic [qtg_pkg::Q_W-1:0]        qd [3];
	logic signed [qtg_pkg::TAN_W-1:0] tan_x_q, tan_y_q, tan_z_q;

	qtg_pkg::step_ctl_t dot_ctl, sq_ctl, rt_ctl, dv_ctl;

	logic vtx_acc;

	assign vtx_stall = (idx_q == 2'd3) && (state_q != ST_IDLE);
	assign vtx_acc   = vtx_valid && !vtx_stall;

	always_comb begin
		vin_p[0] = ext_coord(pos_x);
		vin_p[1] = ext_coord(pos_y);
		vin_p[2] = ext_coord(pos_z);
		vin_t[0] = ext_coord(tex_u);
		vin_t[1] = ext_coord(tex_v);
		for (int k = 0; k < 3; k++) begin
			dp1[k] = MW'(hp_q[1][k]) - MW'(hp_q[0][k]);
			dp2[k] = MW'(hp_q[2][k]) - MW'(hp_q[0][k]);
		end
		du1u = MW'(ht_q[1][0]) - MW'(ht_q[0][0]);
		du1v = MW'(ht_q[1][1]) - MW'(ht_q[0][1]);
		du2u = MW'(ht_q[2][0]) - MW'(ht_q[0][0]);
		du2v = MW'(ht_q[2][1]) - MW'(ht_q[0][1]);
	end

	always_comb begin
		dot_ctl.start = vtx_acc && (idx_q == 2'd3);
		dot_ctl.step  = (state_q == ST_DOT);
		dot_ctl.fin   = (state_q == ST_DOT) && (cnt_q == NW'(MW - 1));
		sq_ctl.start  = (state_q == ST_SHIFT) && !need_sh;
		sq_ctl.step   = (state_q == ST_SQ);
		sq_ctl.fin    = (state_q == ST_SQ) && (cnt_q == NW'(qtg_pkg::A_W - 1));
		rt_ctl.start  = (state_q == ST_SUM) && (cnt_q == NW'(1));
		rt_ctl.step   = (state_q == ST_SQRT);
		rt_ctl.fin    = (state_q == ST_SQRT) && (cnt_q == NW'(qtg_pkg::ROOT_W - 1));
		dv_ctl.start  = (state_q == ST_DIV) && (cnt_q == '0);
		dv_ctl.step   = (state_q == ST_DIV) && (cnt_q != '0);
		dv_ctl.fin    = (state_q == ST_DIV) && (cnt_q == NW'(qtg_pkg::Q_W));
	end

	qtg_dot2 #(.MW(MW)) u_det (
		.clk (clk), .ctl (dot_ctl),
		.a (du1u), .b (du2v), .c (du1v), .d (du2u),
		.prod (det_p)
	);

	for (genvar g = 0; g < 3; g++) begin : g_lane
		qtg_dot2 #(.MW(MW)) u_tan (
			.clk (clk), .ctl (dot_ctl),
			.a (dp1[g]), .b (du2v), .c (dp2[g]), .d (du1v),
			.prod (t_p[g])
		);
		qtg_sqmul u_sq (
			.clk (clk), .ctl (sq_ctl),
			.a (mag_q[g][qtg_pkg::A_W-1:0]),
			.sq (sq[g])
		);
		qtg_div u_div (
			.clk (clk), .ctl (dv_ctl),
			.a (mag_q[g][qtg_pkg::A_W-1:0]), .len (len),
			.q (qd[g])
		);
	end

	assign rt_x = sum_q + qtg_pkg::SUM_W'(sq[2]);

	qtg_isqrt u_root (
		.clk (clk), .ctl (rt_ctl),
		.x (rt_x),
		.root (len)
	);

	always_comb begin
		need_sh = 1'b0;
		for (int k = 0; k < 3; k++) begin
			need_sh = need_sh || (|mag_q[k][MG-1:qtg_pkg::A_W]);
		end
		degen_now = (det_p == '0) || ((t_p[0] == '0) && (t_p[1] == '0) && (t_p[2] == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= 2'd0;
			tan_valid_q <= 1'b0;
			corner_q    <= 2'd0;
		end else begin
			if (vtx_acc) begin
				idx_q <= (idx_q == 2'd3) ? 2'd0 : idx_q + 2'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (vtx_acc && (idx_q == 2'd3)) begin
						state_q <= ST_DOT;
						cnt_q   <= '0;
					end
				end
				ST_DOT: begin
					if (dot_ctl.fin) begin
						state_q <= ST_MAG;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_MAG: begin
					state_q <= degen_now ? ST_FIN : ST_SHIFT;
				end
				ST_SHIFT: begin
					if (!need_sh) begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					if (sq_ctl.fin) begin
						state_q <= ST_SUM;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_SUM: begin
					if (rt_ctl.start) begin
						state_q <= ST_SQRT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_SQRT: begin
					if (rt_ctl.fin) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_DIV: begin
					if (dv_ctl.fin) begin
						state_q <= ST_FIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_FIN: begin
					state_q     <= ST_OUT;
					tan_valid_q <= 1'b1;
					corner_q    <= 2'd0;
				end
				ST_OUT: begin
					if (!tan_stall) begin
						if (corner_q == 2'd3) begin
							tan_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else begin
							corner_q <= corner_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_acc && (idx_q != 2'd3)) begin
			for (int k = 0; k < 3; k++) begin
				hp_q[idx_q][k] <= vin_p[k];
			end
			for (int k = 0; k < 2; k++) begin
				ht_q[idx_q][k] <= vin_t[k];
			end
		end
		unique case (state_q)
			ST_MAG: begin
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= MG'($unsigned(t_p[k][RW-1] ? -t_p[k] : t_p[k]));
					neg_q[k] <= t_p[k][RW-1] ^ det_p[RW-1];
				end
				degen_q <= degen_now;
			end
			ST_SHIFT: begin
				if (need_sh) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end
			end
			ST_SUM: begin
				if (cnt_q == '0) begin
					sum_q <= qtg_pkg::SUM_W'(sq[0]) + qtg_pkg::SUM_W'(sq[1]);
				end
			end
			ST_FIN: begin
				tan_x_q <= degen_q ? '0 : mk_comp(qd[0], neg_q[0]);
				tan_y_q <= degen_q ? '0 : mk_comp(qd[1], neg_q[1]);
				tan_z_q <= degen_q ? '0 : mk_comp(qd[2], neg_q[2]);
			end
			ST_IDLE, ST_DOT, ST_SQ, ST_SQRT, ST_DIV, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign tan_valid    = tan_valid_q;
	assign tan_x        = tan_x_q;
	assign tan_y        = tan_y_q;
	assign tan_z        = tan_z_q;
	assign corner       = corner_q;
	assign last_of_quad = (corner_q == 2'd3);
	assign degenerate   = degen_q;

	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		tan_valid |-> (state_q == ST_OUT))
		else $error("result word valid outside output phase");

	a_quad_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(tan_valid && !tan_stall && last_of_quad) |=> !tan_valid)
		else $error("result words continue past last corner");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tan_valid && degenerate) |-> ((tan_x == '0) && (tan_y == '0) && (tan_z == '0)))
		else $error("degenerate word with nonzero tangent");

	a_fourth_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(vtx_valid && !vtx_stall && (idx_q == 2'd3)) |=> (state_q == ST_DOT))
		else $error("fourth vertex did not start quad work");

endmodule
